[hdl/bitmap_block_allocator_assert.svh]
// assertion helpers for the block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

    // field widths
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // default sizing
    localparam int DEF_MAX_BLOCKS    = 4096;
    localparam int DEF_MAP_WORD_BITS = 32;

    // counter ceiling and register reset values
    localparam logic [CNT_W-1:0] COUNTER_MAX = 13'h1FFF;
    localparam logic [IDX_W-1:0] RST_FIRST   = 12'd0;
    localparam logic [CNT_W-1:0] RST_COUNT   = 13'd4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT      = 1'b1;

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

endpackage

[hdl/bba_req_if.sv]
`timescale 1ns / 1ps

interface bba_req_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output action, output block_index, input ready);
    modport sink   (input valid, input action, input block_index, output ready);
endinterface

[hdl/bba_rsp_if.sv]
`timescale 1ns / 1ps

interface bba_rsp_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [IDX_W-1:0] granted_block;
    logic [CNT_W-1:0] free_left;

    modport source (output valid, output status, output granted_block, output free_left,
                    input ready);
    modport sink   (input valid, input status, input granted_block, input free_left,
                    output ready);
endinterface

[hdl/bitmap_block_allocator.sv]
// First-fit block allocator. The used/free bitmap lives in a memory of MAP_WORD_BITS-bit
// words (MAX_BLOCKS/MAP_WORD_BITS words, 128 at the defaults) with one write and one
// read port, read one word per cycle. An allocate beat runs S_EVAL for each bitmap word
// visited from the word holding first_data_block up to the first word with a clear bit
// in range (worst case every word up to block_count-1), then S_RESP; a free beat runs
// S_EVAL once; a request rejected up front (alloc with counter at zero or an empty
// range, free with index out of range) goes to S_RESP. One request is in flight at a
// time; a finished response waits in the output register while the next request is
// taken. After reset a clearing pass writes every bitmap word to zero, during which no
// request is taken; register writes are taken at any time and reload the free counter
// to min(block_count, MAX_BLOCKS) - first_data_block (zero if negative), leaving the
// bitmap alone. MAP_WORD_BITS and MAX_BLOCKS must be powers of two (not checked).
`timescale 1ns / 1ps
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator import bba_pkg::*; #(
    parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
    parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    bba_req_if.sink               i_req,
    bba_rsp_if.source             o_rsp
);

    localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LW        = $clog2(MAP_WORD_BITS);
    localparam int BW        = (AW + LW > CNT_W) ? AW + LW : CNT_W;
    localparam int CAP       = (MAX_BLOCKS > int'(COUNTER_MAX)) ? int'(COUNTER_MAX)
                                                                : MAX_BLOCKS;
    localparam logic [CNT_W-1:0] TOTAL_CAP = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] RST_FREE  =
        (int'(RST_COUNT) > CAP) ? CNT_W'(CAP) : RST_COUNT;
    localparam logic [AW-1:0]            LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [MAP_WORD_BITS-1:0] ONES      = '1;
    localparam logic [MAP_WORD_BITS-1:0] ONE_BIT   = MAP_WORD_BITS'(1);
    localparam logic [LW-1:0]            TOP_BIT   = LW'(MAP_WORD_BITS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_RESP
    } t_state;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_addr, n_addr;
    logic                     r_act, n_act;
    logic [IDX_W-1:0]         r_idx, n_idx;
    t_status                  r_status, n_status;
    logic [IDX_W-1:0]         r_grant, n_grant;
    logic [CNT_W-1:0]         r_free, n_free;
    logic [IDX_W-1:0]         r_first, n_first;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic [IDX_W-1:0]         r_out_grant, n_out_grant;
    logic [CNT_W-1:0]         r_out_free, n_out_free;

    // bitmap memory
    logic [MAP_WORD_BITS-1:0] r_map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] r_rd_data;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic [MAP_WORD_BITS-1:0] mem_wdata;

    logic [CNT_W-1:0]         c_total;
    logic [BW-1:0]            first_b, last_b, req_idx_b, r_idx_b;
    logic [AW-1:0]            start_word, last_word;
    logic [LW-1:0]            start_off, last_off;
    logic                     range_ok, req_in_range;
    logic [MAP_WORD_BITS-1:0] lo_mask, hi_mask, cand;
    logic                     found;
    logic [LW-1:0]            pos;
    logic [CNT_W-1:0]         free_inc;
    logic [IDX_W-1:0]         cfg_first;
    logic [CNT_W-1:0]         cfg_count, cfg_total, cfg_reload;

    // managed range and scan limits
    always_comb begin
        c_total      = (r_count > TOTAL_CAP) ? TOTAL_CAP : r_count;
        first_b      = BW'(r_first);
        last_b       = BW'(c_total) - BW'(1);
        start_word   = first_b[LW +: AW];
        start_off    = first_b[LW-1:0];
        last_word    = last_b[LW +: AW];
        last_off     = last_b[LW-1:0];
        range_ok     = first_b < BW'(c_total);
        req_idx_b    = BW'(i_req.block_index);
        r_idx_b      = BW'(r_idx);
        req_in_range = (req_idx_b >= first_b) && (req_idx_b < BW'(c_total));
        free_inc     = (r_free == COUNTER_MAX) ? r_free : r_free + CNT_W'(1);
    end

    // first clear bit of the fetched word inside the managed range
    always_comb begin
        lo_mask = (r_addr == start_word) ? (ONES << start_off) : ONES;
        hi_mask = (r_addr == last_word) ? (ONES >> (TOP_BIT - last_off)) : ONES;
        cand    = ~r_rd_data & lo_mask & hi_mask;
        found   = |cand;
        pos     = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pos = LW'(i);
            end
        end
    end

    // register write and counter reload value
    always_comb begin
        cfg_first = r_first;
        cfg_count = r_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_DATA_BLOCK: cfg_first = i_cfg_wdata[IDX_W-1:0];
                CFG_BLOCK_COUNT:      cfg_count = i_cfg_wdata;
                default: ;
            endcase
        end
        cfg_total  = (cfg_count > TOTAL_CAP) ? TOTAL_CAP : cfg_count;
        cfg_reload = (CNT_W'(cfg_first) < cfg_total) ? cfg_total - CNT_W'(cfg_first)
                                                       : '0;
    end

    // control path
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_act        = r_act;
        n_idx        = r_idx;
        n_status     = r_status;
        n_grant      = r_grant;
        n_free       = r_free;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        n_out_free   = r_out_free;
        mem_we       = 1'b0;
        mem_wdata    = r_rd_data;
        rd_addr      = r_addr;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_idx   = i_req.block_index;
                    n_grant = '0;
                    if (i_req.action == ACT_ALLOC) begin
                        if (r_free == '0 || !range_ok) begin
                            n_status = ST_NO_SPACE;
                            n_state  = S_RESP;
                        end else begin
                            n_addr  = start_word;
                            n_state = S_EVAL;
                        end
                    end else begin
                        if (!req_in_range) begin
                            n_status = ST_INVALID;
                            n_state  = S_RESP;
                        end else begin
                            n_addr  = req_idx_b[LW +: AW];
                            n_state = S_EVAL;
                        end
                    end
                end
                rd_addr = n_addr;
            end
            S_EVAL: begin
                if (r_act == ACT_ALLOC) begin
                    if (found) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rd_data | (ONE_BIT << pos);
                        n_grant   = IDX_W'({r_addr, pos});
                        n_status  = ST_OK;
                        n_free    = r_free - CNT_W'(1);
                        n_state   = S_RESP;
                    end else if (r_addr == last_word) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_RESP;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data & ~(ONE_BIT << r_idx_b[LW-1:0]);
                    n_status  = ST_OK;
                    n_free    = free_inc;
                    n_state   = S_RESP;
                end
                rd_addr = n_addr;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_grant  = r_grant;
                    n_out_free   = r_free;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a register write reloads the counter
        n_first = cfg_first;
        n_count = cfg_count;
        if (i_cfg_we) begin
            n_free = cfg_reload;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
        r_out_free   <= n_out_free;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_first     <= RST_FIRST;
            r_count     <= RST_COUNT;
            r_free      <= RST_FREE;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_count     <= n_count;
            r_free      <= n_free;
        end
    end

    // bitmap memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map_mem[r_addr] <= mem_wdata;
        end
        r_rd_data <= r_map_mem[rd_addr];
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_block = r_out_grant;
    assign o_rsp.free_left     = r_out_free;

    // checks
    `BBA_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n,
        i_req.valid && i_req.ready,
        r_state != S_IDLE,
        "accepted beat did not start work")
    `BBA_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n,
        (r_state == S_EVAL) && (r_act == ACT_ALLOC),
        (r_addr >= start_word) && (r_addr <= last_word),
        "scan left the managed words")
    `BBA_ASSERT_IMP(a_grant_in_range, i_clk, i_rst_n,
        (r_state == S_RESP) && (r_act == ACT_ALLOC) && (r_status == ST_OK),
        (BW'(r_grant) >= first_b) && (BW'(r_grant) < BW'(c_total)),
        "granted block outside managed range")

endmodule

[test/bitmap_block_allocator_tb.sv]
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int          BLOCKS       = DEF_MAX_BLOCKS;
    localparam int unsigned CYCLE_CAP    = 1_000_000;
    localparam int unsigned DRAIN_CAP    = 20_000;
    localparam int          RAND_ROUNDS  = 8;
    localparam int          ROUND_REQS   = 68;
    localparam int          SPREAD_FREES = 24;
    localparam int          LONG_STALL   = 400;
    localparam int          STALL_AT     = 60;

    // one request beat and one response beat
    typedef struct packed {
        logic             act;
        logic [IDX_W-1:0] idx;
    } t_block_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] free_left;
    } t_alloc_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bba_req_if req_bus ();
    bba_rsp_if rsp_bus ();

    bitmap_block_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    // mirror of the allocator state
    logic [BLOCKS-1:0] model_used;
    logic [CNT_W-1:0]  model_free;
    logic [IDX_W-1:0]  model_first;
    logic [CNT_W-1:0]  model_count;

    t_block_req    pending_reqs[$];
    t_alloc_result expected_results[$];

    int          mismatches;
    int          beats_got;
    int unsigned cycle_count;
    int unsigned send_gap;
    int unsigned rdy_hold;
    bit          long_hold_done;
    bit          calm;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned managed_total();
        return (model_count > BLOCKS) ? BLOCKS : model_count;
    endfunction

    function automatic void reload_free();
        int unsigned total;
        total = managed_total();
        model_free = (model_first < total) ? CNT_W'(total - model_first) : '0;
    endfunction

    // first-fit allocate or free against the mirror, returns the response beat
    function automatic t_alloc_result serve_request(input logic act,
                                                    input logic [IDX_W-1:0] idx);
        t_alloc_result res;
        int unsigned   total;
        bit            found;
        total       = managed_total();
        res.status  = ST_OK;
        res.granted = '0;
        found       = 1'b0;
        if (act == ACT_ALLOC) begin
            res.status = ST_NO_SPACE;
            if (model_free != 0) begin
                for (int unsigned b = model_first; b < total && !found; b++) begin
                    if (!model_used[b]) begin
                        model_used[b] = 1'b1;
                        model_free    = model_free - 1'b1;
                        res.granted   = IDX_W'(b);
                        res.status    = ST_OK;
                        found         = 1'b1;
                    end
                end
            end
        end else if (idx < model_first || idx >= total) begin
            res.status = ST_INVALID;
        end else begin
            // freeing a clear block still bumps the counter, up to the ceiling
            model_used[idx] = 1'b0;
            if (model_free != COUNTER_MAX)
                model_free = model_free + 1'b1;
        end
        res.free_left = model_free;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at beat %0d: %s got %0d expected %0d", beats_got, what, got, want);
    endtask

    task automatic queue_req(input logic act, input logic [IDX_W-1:0] idx);
        t_block_req r;
        r.act = act;
        r.idx = idx;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (which == CFG_FIRST_DATA_BLOCK)
            model_first = value[IDX_W-1:0];
        else
            model_count = value;
        reload_free();
        @(negedge i_clk);
    endtask

    // sender paused until every outstanding response is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0);
    endtask

    // request driver
    always @(posedge i_clk) begin
        int unsigned gap;
        t_block_req  nxt;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap      <= 0;
        end else if (!req_bus.valid || req_bus.ready) begin
            gap = req_bus.valid ? idle_length() : send_gap;
            if (gap != 0) begin
                req_bus.valid <= 1'b0;
                send_gap      <= gap - 1;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                req_bus.valid       <= 1'b1;
                req_bus.action      <= nxt.act;
                req_bus.block_index <= nxt.idx;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // response ready, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        int unsigned g;
        if (!i_rst_n) begin
            rsp_bus.ready  <= 1'b0;
            rdy_hold       <= 0;
            long_hold_done <= 1'b0;
        end else if (!long_hold_done && beats_got >= STALL_AT) begin
            rsp_bus.ready  <= 1'b0;
            rdy_hold       <= LONG_STALL;
            long_hold_done <= 1'b1;
        end else if (rdy_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rdy_hold      <= rdy_hold - 1;
        end else begin
            g = (!calm && $urandom_range(0, 3) == 0) ? idle_length() : 0;
            if (g != 0) begin
                rsp_bus.ready <= 1'b0;
                rdy_hold      <= g - 1;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // check response beats, then predict for the request beat taken this edge
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                beats_got <= beats_got + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("response with nothing outstanding", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", rsp_bus.status, want.status);
                    if (rsp_bus.granted_block !== want.granted)
                        report_mismatch("granted_block", rsp_bus.granted_block, want.granted);
                    if (rsp_bus.free_left !== want.free_left)
                        report_mismatch("free_left", rsp_bus.free_left, want.free_left);
                end
            end
            if (req_bus.valid && req_bus.ready)
                expected_results.push_back(serve_request(req_bus.action, req_bus.block_index));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned sel;
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        int unsigned waited;

        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_FIRST_DATA_BLOCK;
        cfg_wdata           = '0;
        req_bus.valid       = 1'b0;
        req_bus.action      = ACT_ALLOC;
        req_bus.block_index = '0;
        rsp_bus.ready       = 1'b0;
        mismatches          = 0;
        beats_got           = 0;
        cycle_count         = 0;
        calm                = 1'b0;
        model_used          = '0;
        model_first         = RST_FIRST;
        model_count         = RST_COUNT;
        reload_free();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // top six blocks only: exhaust the counter, stale count, double free
        write_reg(CFG_FIRST_DATA_BLOCK, 13'd4090);
        write_reg(CFG_BLOCK_COUNT, 13'd4096);
        repeat (7) queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, 12'd4095);
        queue_req(ACT_FREE, 12'd4089);
        queue_req(ACT_FREE, 12'd0);
        queue_req(ACT_FREE, 12'd4090);
        queue_req(ACT_FREE, 12'd4090);
        repeat (3) queue_req(ACT_ALLOC, 12'hFFF);
        wait_idle();

        // count above the block limit is clamped; single block at the top
        write_reg(CFG_BLOCK_COUNT, 13'd8191);
        write_reg(CFG_FIRST_DATA_BLOCK, 13'd4095);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, 12'd4095);
        queue_req(ACT_ALLOC, '0);
        wait_idle();

        // start above the total: nothing to allocate, every free rejected
        write_reg(CFG_FIRST_DATA_BLOCK, 13'd100);
        write_reg(CFG_BLOCK_COUNT, 13'd50);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, 12'd100);
        queue_req(ACT_FREE, 12'd49);
        wait_idle();

        // zero blocks managed
        write_reg(CFG_FIRST_DATA_BLOCK, 13'd0);
        write_reg(CFG_BLOCK_COUNT, 13'd0);
        queue_req(ACT_ALLOC, '0);
        queue_req(ACT_FREE, 12'd0);
        wait_idle();

        // random rounds, mostly small windows with allocs and in-range frees
        for (int round = 0; round < RAND_ROUNDS; round++) begin
            calm = ($urandom_range(0, 3) == 0);
            sel  = $urandom_range(0, 9);
            if (sel < 6) begin
                lo = $urandom_range(0, BLOCKS - 1);
                write_reg(CFG_FIRST_DATA_BLOCK, CFG_DATA_W'(lo));
                write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(lo + $urandom_range(1, 96)));
            end else if (sel < 8) begin
                // reload the counter over a bitmap that is left as it is
                if ($urandom_range(0, 1))
                    write_reg(CFG_FIRST_DATA_BLOCK, CFG_DATA_W'($urandom_range(0, BLOCKS - 1)));
                else
                    write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'($urandom_range(0, 8191)));
            end else begin
                write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'($urandom_range(0, 8191)));
                write_reg(CFG_FIRST_DATA_BLOCK, CFG_DATA_W'($urandom_range(0, BLOCKS - 1)));
            end
            lo = model_first;
            hi = managed_total();
            for (int k = 0; k < ROUND_REQS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    queue_req(ACT_ALLOC, IDX_W'($urandom));
                else if (r < 85 && lo < hi)
                    queue_req(ACT_FREE, IDX_W'($urandom_range(lo, hi - 1)));
                else
                    queue_req(ACT_FREE, IDX_W'($urandom));
            end
            wait_idle();
        end

        // frees across the whole range push the counter past the free block total
        calm = 1'b1;
        write_reg(CFG_FIRST_DATA_BLOCK, 13'd0);
        write_reg(CFG_BLOCK_COUNT, 13'd4096);
        for (int k = 0; k < SPREAD_FREES; k++)
            queue_req(ACT_FREE, IDX_W'($urandom_range(0, BLOCKS - 1)));
        repeat (20) queue_req(ACT_ALLOC, '0);
        wait_idle();

        // closing round with idling back on
        calm = 1'b0;
        write_reg(CFG_BLOCK_COUNT, 13'd64);
        for (int k = 0; k < 40; k++)
            queue_req(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 70)));

        // drain, then give stray beats a chance to show up
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_bus.valid);
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_CAP) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (150) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("responses never returned", 0, expected_results.size());

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bitmap_block_allocator.sv
test/bitmap_block_allocator_tb.sv
